// File: sv/tdfm_pkg.sv
package tdfm_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int TILE_W       = 8;
  localparam int TILE_H       = 8;
  localparam int PIXEL_BITS   = 2;
  localparam int PALETTE_BITS = 3;

  localparam int ROW_BITS   = TILE_W * PIXEL_BITS;
  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int ROW_SEL_W  = $clog2(TILE_H);
  localparam int ROW_DEPTH  = TABLE_DEPTH * TILE_H;

  // Fixed field widths of the channels.
  localparam int ROW_IDX_W    = 3;
  localparam int PIX_FIELD_W  = 16;
  localparam int PAL_FIELD_W  = 3;
  localparam int TILE_INDEX_W = 8;
  localparam int FLIP_W       = 2;
  localparam int TILE_COUNT_W = 9;

  typedef enum logic [FLIP_W-1:0] {
    FLIP_NONE = 2'd0,
    FLIP_H    = 2'd1,
    FLIP_V    = 2'd2,
    FLIP_HV   = 2'd3
  } flip_e;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cand_wr;
    logic load_job;
    logic next_tile;
    logic next_form;
    logic next_row;
    logic clr_row;
    logic set_found;
    logic wr_row;
    logic commit;
    logic set_full;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_ok;
    logic row_last_item;
    logic t_at_end;
    logic pal_eq;
    logic row_eq;
    logic r_last;
    logic f_last;
    logic insert_ok;
    logic is_insert;
    logic out_free;
  } sts_t;

  function automatic logic [ROW_BITS-1:0] mirror_row(input logic [ROW_BITS-1:0] row);
    logic [ROW_BITS-1:0] res;
    res = '0;
    for (int i = 0; i < TILE_W; i++) begin
      res[(TILE_W-1-i)*PIXEL_BITS +: PIXEL_BITS] = row[i*PIXEL_BITS +: PIXEL_BITS];
    end
    return res;
  endfunction

endpackage

// File: sv/tdfm_intf.sv
interface tdfm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [tdfm_pkg::ROW_IDX_W-1:0]   row_index;
  logic [tdfm_pkg::PIX_FIELD_W-1:0] row_pixels;
  logic [tdfm_pkg::PAL_FIELD_W-1:0] pal_num;

  modport source(output valid, func, row_index, row_pixels, pal_num, input ready);
  modport sink(input valid, func, row_index, row_pixels, pal_num, output ready);
endinterface

interface tdfm_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [tdfm_pkg::TILE_INDEX_W-1:0] tile_index;
  logic [tdfm_pkg::FLIP_W-1:0]       flip_code;
  logic                              stored;
  logic                              table_full;
  logic [tdfm_pkg::TILE_COUNT_W-1:0] tile_count;

  modport source(output valid, found, tile_index, flip_code, stored, table_full, tile_count,
                 input ready);
  modport sink(input valid, found, tile_index, flip_code, stored, table_full, tile_count,
               output ready);
endinterface

// File: sv/tdfm_ram.sv
module tdfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tdfm_ctrl.sv
module tdfm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tdfm_pkg::sts_t sts_i,
  output tdfm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAL_RD,
    S_PAL_CHK,
    S_ROW_RD,
    S_ROW_CHK,
    S_NOMATCH,
    S_WRITE,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.cand_wr = accept && sts_i.row_ok;
        if (accept && sts_i.row_last_item) begin
          cmd_o.load_job = 1'b1;
          state_d        = S_PAL_RD;
        end
      end
      S_PAL_RD: begin
        state_d = sts_i.t_at_end ? S_NOMATCH : S_PAL_CHK;
      end
      S_PAL_CHK: begin
        if (sts_i.pal_eq) begin
          state_d = S_ROW_RD;
        end else begin
          cmd_o.next_tile = 1'b1;
          state_d         = S_PAL_RD;
        end
      end
      S_ROW_RD: begin
        state_d = S_ROW_CHK;
      end
      S_ROW_CHK: begin
        if (sts_i.row_eq) begin
          if (sts_i.r_last) begin
            cmd_o.set_found = 1'b1;
            state_d         = S_RESULT;
          end else begin
            cmd_o.next_row = 1'b1;
            state_d        = S_ROW_RD;
          end
        end else if (sts_i.f_last) begin
          cmd_o.next_tile = 1'b1;
          state_d         = S_PAL_RD;
        end else begin
          cmd_o.next_form = 1'b1;
          state_d         = S_ROW_RD;
        end
      end
      S_NOMATCH: begin
        if (sts_i.insert_ok) begin
          cmd_o.clr_row = 1'b1;
          state_d       = S_WRITE;
        end else begin
          cmd_o.set_full = sts_i.is_insert;
          state_d        = S_RESULT;
        end
      end
      S_WRITE: begin
        cmd_o.wr_row = 1'b1;
        if (sts_i.r_last) begin
          cmd_o.commit = 1'b1;
          state_d      = S_RESULT;
        end else begin
          cmd_o.next_row = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/tdfm_dp.sv
module tdfm_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tdfm_pkg::cmd_t                     cmd_i,
  output tdfm_pkg::sts_t                     sts_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,
  input  logic                               func_i,
  input  logic [tdfm_pkg::ROW_IDX_W-1:0]     row_index_i,
  input  logic [tdfm_pkg::PIX_FIELD_W-1:0]   row_pixels_i,
  input  logic [tdfm_pkg::PAL_FIELD_W-1:0]   pal_num_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               found_o,
  output logic [tdfm_pkg::TILE_INDEX_W-1:0]  tile_index_o,
  output logic [tdfm_pkg::FLIP_W-1:0]        flip_code_o,
  output logic                               stored_o,
  output logic                               table_full_o,
  output logic [tdfm_pkg::TILE_COUNT_W-1:0]  tile_count_o
);

  localparam int RW = tdfm_pkg::ROW_BITS;
  localparam int CW = tdfm_pkg::CNT_W;
  localparam int IW = tdfm_pkg::IDX_W;
  localparam int SW = tdfm_pkg::ROW_SEL_W;
  localparam int PW = tdfm_pkg::PALETTE_BITS;

  logic                      flips_q;
  logic [RW-1:0]             cand_q [tdfm_pkg::TILE_H];
  logic                      func_q;
  logic [PW-1:0]             pal_q;
  logic [CW-1:0]             t_q;
  logic [SW-1:0]             r_q;
  logic [tdfm_pkg::FLIP_W-1:0] f_q;
  logic [CW-1:0]             count_q;
  logic                      out_valid_q;

  logic                      res_found_q, res_stored_q, res_full_q;
  logic [IW-1:0]             res_idx_q;
  logic [tdfm_pkg::FLIP_W-1:0] res_flip_q;

  logic                      out_found_q, out_stored_q, out_full_q;
  logic [IW-1:0]             out_idx_q;
  logic [tdfm_pkg::FLIP_W-1:0] out_flip_q;
  logic [CW-1:0]             out_count_q;

  logic [SW-1:0]             src_row;
  logic [RW-1:0]             row_rdata, row_cmp;
  logic [PW-1:0]             pal_rdata;

  // A vertical flip walks the stored rows from the bottom.
  assign src_row = f_q[1] ? SW'(tdfm_pkg::TILE_H - 1) - r_q : r_q;
  assign row_cmp = f_q[0] ? tdfm_pkg::mirror_row(row_rdata) : row_rdata;

  tdfm_ram #(.WIDTH(RW), .DEPTH(tdfm_pkg::ROW_DEPTH)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_row),
    .waddr_i ({count_q[IW-1:0], r_q}),
    .wdata_i (cand_q[r_q]),
    .raddr_i ({t_q[IW-1:0], src_row}),
    .rdata_o (row_rdata)
  );

  tdfm_ram #(.WIDTH(PW), .DEPTH(tdfm_pkg::TABLE_DEPTH)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (pal_q),
    .raddr_i (t_q[IW-1:0]),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    sts_o.row_ok        = ({1'b0, row_index_i} <
                           (tdfm_pkg::ROW_IDX_W + 1)'(tdfm_pkg::TILE_H));
    sts_o.row_last_item = ({1'b0, row_index_i} ==
                           (tdfm_pkg::ROW_IDX_W + 1)'(tdfm_pkg::TILE_H - 1));
    sts_o.t_at_end      = (t_q == count_q);
    sts_o.pal_eq        = (pal_rdata == pal_q);
    sts_o.row_eq        = (row_cmp == cand_q[r_q]);
    sts_o.r_last        = (r_q == SW'(tdfm_pkg::TILE_H - 1));
    sts_o.f_last        = !flips_q || (f_q == tdfm_pkg::FLIP_HV);
    sts_o.is_insert     = (func_q == tdfm_pkg::FUNC_INSERT);
    sts_o.insert_ok     = sts_o.is_insert && (count_q < CW'(tdfm_pkg::TABLE_DEPTH));
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flips_q     <= 1'b0;
      for (int i = 0; i < tdfm_pkg::TILE_H; i++) begin
        cand_q[i] <= '0;
      end
      t_q         <= '0;
      r_q         <= '0;
      f_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        flips_q <= cfg_wdata_i;
      end
      if (cmd_i.cand_wr) begin
        cand_q[row_index_i[SW-1:0]] <= row_pixels_i[RW-1:0];
      end
      if (cmd_i.load_job) begin
        t_q <= '0;
        r_q <= '0;
        f_q <= '0;
      end else if (cmd_i.next_tile) begin
        t_q <= t_q + CW'(1);
        r_q <= '0;
        f_q <= '0;
      end else if (cmd_i.next_form) begin
        f_q <= f_q + tdfm_pkg::FLIP_W'(1);
        r_q <= '0;
      end else if (cmd_i.next_row) begin
        r_q <= r_q + SW'(1);
      end else if (cmd_i.clr_row) begin
        r_q <= '0;
      end
      if (cmd_i.commit) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_job) begin
      func_q       <= func_i;
      pal_q        <= pal_num_i[PW-1:0];
      res_found_q  <= 1'b0;
      res_stored_q <= 1'b0;
      res_full_q   <= 1'b0;
      res_idx_q    <= '0;
      res_flip_q   <= '0;
    end else begin
      if (cmd_i.set_found) begin
        res_found_q <= 1'b1;
        res_idx_q   <= t_q[IW-1:0];
        res_flip_q  <= f_q;
      end
      if (cmd_i.commit) begin
        res_stored_q <= 1'b1;
        res_idx_q    <= count_q[IW-1:0];
      end
      if (cmd_i.set_full) begin
        res_full_q <= 1'b1;
      end
    end
    if (cmd_i.load_out) begin
      out_found_q  <= res_found_q;
      out_idx_q    <= res_idx_q;
      out_flip_q   <= res_flip_q;
      out_stored_q <= res_stored_q;
      out_full_q   <= res_full_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign tile_index_o = tdfm_pkg::TILE_INDEX_W'(out_idx_q);
  assign flip_code_o  = out_flip_q;
  assign stored_o     = out_stored_q;
  assign table_full_o = out_full_q;
  assign tile_count_o = tdfm_pkg::TILE_COUNT_W'(out_count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(tdfm_pkg::TABLE_DEPTH))
    else $error("tile count beyond table depth");

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (count_q < CW'(tdfm_pkg::TABLE_DEPTH)) && sts_o.is_insert)
    else $error("tile stored without room or outside insert");

  a_found_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_found |-> (t_q < count_q) && sts_o.pal_eq)
    else $error("match reported on a tile that is not held");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still waiting");

endmodule

// File: sv/tile_dedup_flip_match.sv
// Channel | Role   | Handshake                  | Carries
// in_i    | sink   | valid/ready, both high     | func, row_index, row_pixels, pal_num
// out_o   | source | valid/ready, both high     | found, tile_index, flip_code, stored,
//         |        |                            | table_full, tile_count
// cfg     | input  | cfg_we_i, no back-pressure | cfg_wdata_i, the flip matching enable
//
// A row item other than the last row is taken while idle. The last row starts a search:
// for each held tile the palette is read and checked, then the rows are read and compared
// in each flip form. A miss over all held tiles stores the new tile row by row on insert
// while the table has room, then posts the result; only then is the next item taken.
// Reset is immediate: no clearing pass, the tile count marks which entries hold data.
// A stalled result holds back the next search result and, with it, further row intake.
module tile_dedup_flip_match (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  tdfm_in_if.sink    in_i,
  tdfm_out_if.source out_o
);

  tdfm_pkg::cmd_t cmd;
  tdfm_pkg::sts_t sts;

  // The controller sequences palette checks, row compares across flip forms and
  // the row-by-row copy of a new tile; the datapath owns all storage.
  tdfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tdfm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (in_i.func),
    .row_index_i     (in_i.row_index),
    .row_pixels_i    (in_i.row_pixels),
    .pal_num_i       (in_i.pal_num),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .found_o         (out_o.found),
    .tile_index_o    (out_o.tile_index),
    .flip_code_o     (out_o.flip_code),
    .stored_o        (out_o.stored),
    .table_full_o    (out_o.table_full),
    .tile_count_o    (out_o.tile_count)
  );

endmodule
